// ===== design/bayer_rggb_bilinear_demosaic_assert.svh =====
// Assertion macros shared by the demosaic RTL.
`ifndef BAYER_RGGB_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_RGGB_BILINEAR_DEMOSAIC_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BRBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BRBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/brbd_pkg.sv =====
// Types and constants of the RGGB bilinear demosaic block.
`default_nettype none

package brbd_pkg;

  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int CFG_W            = 13;
  localparam int ROW_W            = 13;
  localparam int PIX_W            = 8;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Input opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Output queue.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // 3x3 window: index row*3 + column, rows top to bottom, columns left to right.
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             row_end;
    logic             frame_end;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bayer_rggb_bilinear_demosaic.sv =====
// Top level of the streaming RGGB Bayer to RGB bilinear demosaic.
//
// This block takes 8-bit RGGB Bayer samples in raster order and returns one
// RGB pixel per sample, interpolated bilinearly from its 3x3 neighborhood with
// edge pixels replicated outside the frame. Output pixels trail the input by
// one row plus one column: the first row of a frame produces nothing, and the
// transaction that ends a row also produces the rightmost pixel of the row
// above, so it gives two results. After the last row the host sends
// frame_width drain transactions (opcode 1), which flush the final pixel row.
// The block accepts one transaction per clock while the input is not stalled.
// Each accepted sample reads the two row memories (MAX_WIDTH x 8 each,
// registered read) in the cycle it is taken, and stage 1 writes them back and
// updates the window when it fires; a same-address write and read
// (one-pixel-wide frames) is bypassed. Results pass through a four-entry
// output queue; the input is stalled while stage 1 holds an item and the
// queue holds more than two results. With a free-running output the queue
// never holds more than two, so the two-result row ends never stall the input.
// The row memories are not cleared after reset; the counters keep unwritten
// entries from being used. Writing frame_width or frame_height restarts the
// frame and must only happen while the block is idle.
`default_nettype none

module bayer_rggb_bilinear_demosaic
  import brbd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_opcode,
  input  wire logic [PIX_W-1:0]     in_sample,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIX_W-1:0]          out_red,
  output logic [PIX_W-1:0]          out_green,
  output logic [PIX_W-1:0]          out_blue,
  output logic                      out_row_end,
  output logic                      out_frame_end,
  output logic                      out_last
);

  `include "bayer_rggb_bilinear_demosaic_assert.svh"

  // Column address width and a compare width that holds both the register
  // value and MAX_WIDTH itself.
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (WW > CFG_W) ? WW : CFG_W;
  localparam int RST_WD = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

  // Builds one output pixel from the window. The Bayer phase comes from the
  // parity of the pixel's row and column.
  function automatic result_t make_pixel(input win_t k, input logic xe, input logic ye,
                                         input logic row_end, input logic frame_end,
                                         input logic last);
    logic [PIX_W:0]   hz;
    logic [PIX_W:0]   vt;
    logic [PIX_W+1:0] dg;
    logic [PIX_W+1:0] cr;
    result_t          res;
    hz = {1'b0, k[3]} + {1'b0, k[5]};
    vt = {1'b0, k[1]} + {1'b0, k[7]};
    dg = {2'b00, k[0]} + {2'b00, k[2]} + {2'b00, k[6]} + {2'b00, k[8]};
    cr = {1'b0, hz} + {1'b0, vt};
    if (ye && xe) begin
      res.red   = k[4];
      res.green = cr[PIX_W+1:2];
      res.blue  = dg[PIX_W+1:2];
    end else if (ye) begin
      res.red   = hz[PIX_W:1];
      res.green = k[4];
      res.blue  = vt[PIX_W:1];
    end else if (xe) begin
      res.red   = vt[PIX_W:1];
      res.green = k[4];
      res.blue  = hz[PIX_W:1];
    end else begin
      res.red   = dg[PIX_W+1:2];
      res.green = cr[PIX_W+1:2];
      res.blue  = k[4];
    end
    res.row_end   = row_end;
    res.frame_end = frame_end;
    res.last      = last;
    return res;
  endfunction

  // Configuration, kept in the form the datapath uses: last column index and
  // last row index.
  logic [CW-1:0]    wm1_r, wm1_nxt;
  logic [ROW_W-1:0] hm1_r, hm1_nxt;
  logic [EW-1:0]    fw_ext;

  // Position of the next input.
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]    x_cur;
  logic             accept;

  // Stage 1: the accepted item while the row memories are read.
  logic             s1_valid_r, s1_valid_nxt;
  logic [CW-1:0]    s1_x_r;
  logic [ROW_W-1:0] s1_y_r;
  logic             s1_drain_r;
  logic [PIX_W-1:0] s1_sample_r;
  logic             s1_fire;

  // Row memories and their registered read data.
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_rd_r;
  logic [PIX_W-1:0] newer_rd_r;

  // Bypass for a read issued in the same cycle as a write to its address.
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [PIX_W-1:0] fwd_older_r;
  logic [PIX_W-1:0] fwd_newer_r;

  // Window and stage 1 datapath.
  win_t             win_r;
  win_t             win1;
  win_t             win2;
  logic [PIX_W-1:0] older_q, newer_q;
  logic [PIX_W-1:0] top, mid, bot;
  logic             at_end;
  logic             emit_a, emit_b;
  logic [ROW_W-1:0] py;
  logic [CW-1:0]    px_a;
  logic             py_last;
  result_t          res_a, res_b;

  // Output queue.
  result_t              oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]     oq_wp_r, oq_wp_nxt;
  logic [OQ_AW-1:0]     oq_rp_r, oq_rp_nxt;
  logic [OQ_CNT_W-1:0]  oq_cnt_r, oq_cnt_nxt;
  logic                 oq_room;
  logic                 oq_pop;
  logic [1:0]           push_n;

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------
  assign oq_room  = oq_cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign s1_fire  = s1_valid_r && oq_room;
  assign in_stall = s1_valid_r && !oq_room;
  assign accept   = in_valid && !in_stall;
  assign x_cur    = (col_cnt_r > wm1_r) ? '0 : col_cnt_r;
  assign fw_ext   = EW'(cfg_data);

  always_comb begin
    wm1_nxt     = wm1_r;
    hm1_nxt     = hm1_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
      // A configuration write restarts the frame.
      if (cfg_index == REG_FRAME_WIDTH) begin
        if (fw_ext == '0) begin
          wm1_nxt = '0;
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
          wm1_nxt = CW'(MAX_WIDTH - 1);
        end else begin
          wm1_nxt = CW'(fw_ext - EW'(1));
        end
      end else begin
        hm1_nxt = (cfg_data == '0) ? '0 : ROW_W'(cfg_data - CFG_W'(1));
      end
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (accept) begin
      if (x_cur == wm1_r) begin
        col_cnt_nxt = '0;
        // A drain transaction that ends a row also ends the frame.
        row_cnt_nxt = (in_opcode == OP_DRAIN) ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_nxt = x_cur + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read-modify-write of the row memories, window shift and
  // interpolation of up to two pixels.
  // ---------------------------------------------------------------------------
  always_comb begin
    older_q = fwd_hit_r ? fwd_older_r : older_rd_r;
    newer_q = fwd_hit_r ? fwd_newer_r : newer_rd_r;
    mid     = newer_q;
    // The first two rows have no row two above; the top neighbor is the
    // middle one replicated.
    top     = (s1_y_r >= ROW_W'(2)) ? older_q : mid;
    // A drain stands for a replicated bottom row.
    bot     = (s1_drain_r == OP_DRAIN) ? mid : s1_sample_r;

    // The first column of a row fills the whole window with its column.
    if (s1_x_r == '0) begin
      for (int c = 0; c < 3; c++) begin
        win1[c]     = top;
        win1[3 + c] = mid;
        win1[6 + c] = bot;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        win1[r*3 + 0] = win_r[r*3 + 1];
        win1[r*3 + 1] = win_r[r*3 + 2];
      end
      win1[2] = top;
      win1[5] = mid;
      win1[8] = bot;
    end

    // At the right edge the last pixel sees its own column replicated.
    win2 = win1;
    if (s1_x_r != '0) begin
      for (int r = 0; r < 3; r++) begin
        win2[r*3 + 0] = win1[r*3 + 1];
        win2[r*3 + 1] = win1[r*3 + 2];
        win2[r*3 + 2] = win1[r*3 + 2];
      end
    end

    at_end  = s1_x_r == wm1_r;
    emit_a  = (s1_y_r != '0) && (s1_x_r != '0);
    emit_b  = at_end && (s1_y_r != '0);
    py      = s1_y_r - ROW_W'(1);
    px_a    = s1_x_r - CW'(1);
    py_last = py == hm1_r;

    res_a = make_pixel(win1, !px_a[0], !py[0], px_a == wm1_r,
                       (px_a == wm1_r) && py_last, !emit_b);
    res_b = make_pixel(win2, !s1_x_r[0], !py[0], at_end, at_end && py_last, 1'b1);

    push_n = '0;
    if (s1_fire) begin
      push_n = {1'b0, emit_a} + {1'b0, emit_b};
    end

    fwd_hit_nxt = 1'b0;
    if (accept) begin
      fwd_hit_nxt = s1_fire && (s1_x_r == x_cur);
    end else begin
      fwd_hit_nxt = fwd_hit_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue.
  // ---------------------------------------------------------------------------
  assign out_valid     = oq_cnt_r != '0;
  assign oq_pop        = out_valid && !out_stall;
  assign out_red       = oq_mem_r[oq_rp_r].red;
  assign out_green     = oq_mem_r[oq_rp_r].green;
  assign out_blue      = oq_mem_r[oq_rp_r].blue;
  assign out_row_end   = oq_mem_r[oq_rp_r].row_end;
  assign out_frame_end = oq_mem_r[oq_rp_r].frame_end;
  assign out_last      = oq_mem_r[oq_rp_r].last;

  always_comb begin
    oq_wp_nxt  = oq_wp_r + OQ_AW'(push_n);
    oq_rp_nxt  = oq_pop ? oq_rp_r + OQ_AW'(1) : oq_rp_r;
    oq_cnt_nxt = oq_cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(oq_pop);
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r      <= CW'(RST_WD - 1);
      hm1_r      <= ROW_W'(FRAME_HEIGHT_RST - 1);
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      win_r      <= '0;
      oq_wp_r    <= '0;
      oq_rp_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      wm1_r      <= wm1_nxt;
      hm1_r      <= hm1_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      fwd_hit_r  <= fwd_hit_nxt;
      if (s1_fire) begin
        win_r <= win1;
      end
      oq_wp_r  <= oq_wp_nxt;
      oq_rp_r  <= oq_rp_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r      <= x_cur;
      s1_y_r      <= row_cnt_r;
      s1_drain_r  <= in_opcode;
      s1_sample_r <= in_sample;
      fwd_older_r <= mid;
      fwd_newer_r <= bot;
    end
    if (s1_fire && emit_a) begin
      oq_mem_r[oq_wp_r] <= res_a;
      if (emit_b) begin
        oq_mem_r[oq_wp_r + OQ_AW'(1)] <= res_b;
      end
    end else if (s1_fire && emit_b) begin
      oq_mem_r[oq_wp_r] <= res_b;
    end
  end

  // Row memories: read when an item is accepted, written back by stage 1.
  always_ff @(posedge clk) begin
    if (accept) begin
      older_rd_r <= older_mem[x_cur];
      newer_rd_r <= newer_mem[x_cur];
    end
    if (s1_fire) begin
      older_mem[s1_x_r] <= mid;
      newer_mem[s1_x_r] <= bot;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `BRBD_ASSERT_NOW(a_oq_bound, clk, rst_n, 1'b1, oq_cnt_r <= OQ_CNT_W'(OQ_DEPTH),
                   "output queue overflow")
  `BRBD_ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, col_cnt_r <= wm1_r,
                   "column counter beyond row")
  `BRBD_ASSERT_NOW(a_stall_cause, clk, rst_n, !s1_valid_r, !in_stall,
                   "input stalled with empty stage")
  `BRBD_ASSERT_NEXT(a_push_shows, clk, rst_n, s1_fire && (emit_a || emit_b), out_valid,
                    "pushed result not visible")

endmodule

`default_nettype wire

// ===== tb/demosaic_checker.sv =====
// Result checker for the RGGB bilinear demosaic: predicts each pixel and compares it.
module demosaic_checker
  import brbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [PIX_W-1:0]     in_sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     out_red,
  input  logic [PIX_W-1:0]     out_green,
  input  logic [PIX_W-1:0]     out_blue,
  input  logic                 out_row_end,
  input  logic                 out_frame_end,
  input  logic                 out_last,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  logic [CFG_W-1:0] width_reg = CFG_W'(FRAME_WIDTH_RST);
  logic [CFG_W-1:0] height_reg = CFG_W'(FRAME_HEIGHT_RST);
  logic [PIX_W-1:0] line_two_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_one_up [MAX_WIDTH_DEF];
  int unsigned      col_pos = 0;
  logic [ROW_W-1:0] row_pos = '0;
  win_t             taps = '0;
  result_t          expected_pixels [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // Slides the 3x3 window one column to the left and loads a new right column.
  function automatic void shift_column(logic [PIX_W-1:0] t, logic [PIX_W-1:0] m,
                                       logic [PIX_W-1:0] b);
    taps[0] = taps[1]; taps[1] = taps[2]; taps[2] = t;
    taps[3] = taps[4]; taps[4] = taps[5]; taps[5] = m;
    taps[6] = taps[7]; taps[7] = taps[8]; taps[8] = b;
  endfunction

  // Bilinear interpolation of the window center at pixel (px, py).
  function automatic result_t interpolate(int unsigned px, logic [ROW_W-1:0] py,
                                          int unsigned w, int unsigned h);
    logic [9:0] horiz;
    logic [9:0] vert;
    logic [9:0] diag;
    result_t    pix;
    horiz = taps[3] + taps[5];
    vert  = taps[1] + taps[7];
    diag  = taps[0] + taps[2] + taps[6] + taps[8];
    if (!py[0] && !px[0]) begin
      pix.red   = taps[4];
      pix.green = PIX_W'((horiz + vert) >> 2);
      pix.blue  = PIX_W'(diag >> 2);
    end else if (!py[0]) begin
      pix.red   = PIX_W'(horiz >> 1);
      pix.green = taps[4];
      pix.blue  = PIX_W'(vert >> 1);
    end else if (!px[0]) begin
      pix.red   = PIX_W'(vert >> 1);
      pix.green = taps[4];
      pix.blue  = PIX_W'(horiz >> 1);
    end else begin
      pix.red   = PIX_W'(diag >> 2);
      pix.green = PIX_W'((horiz + vert) >> 2);
      pix.blue  = taps[4];
    end
    pix.row_end   = (px == w - 1);
    pix.frame_end = (px == w - 1) && (py == h - 1);
    pix.last      = 1'b0;
    return pix;
  endfunction

  function automatic void flag(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d row_end=%b frame_end=%b last=%b",
               $realtime, what, want.red, want.green, want.blue, want.row_end,
               want.frame_end, want.last);
      $display("%0t: %s: got      r=%0d g=%0d b=%0d row_end=%b frame_end=%b last=%b",
               $realtime, what, got.red, got.green, got.blue, got.row_end,
               got.frame_end, got.last);
    end
  endfunction

  always @(posedge clk) begin : tracker
    int unsigned      w;
    int unsigned      h;
    int unsigned      x;
    logic [ROW_W-1:0] y;
    logic [ROW_W-1:0] py;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    logic [PIX_W-1:0] bot_px;
    result_t          made [2];
    int               n;
    result_t          want;
    result_t          got;
    if (!rst_n) begin
      width_reg = CFG_W'(FRAME_WIDTH_RST);
      height_reg = CFG_W'(FRAME_HEIGHT_RST);
      col_pos = 0;
      row_pos = '0;
      taps = '0;
      expected_pixels.delete();
    end else begin
      // A write to either register restarts the frame; other indexes do nothing.
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_reg = cfg_data;
          col_pos = 0;
          row_pos = '0;
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          height_reg = cfg_data;
          col_pos = 0;
          row_pos = '0;
        end
      end

      if (in_valid && !in_stall) begin
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        x = (col_pos >= w) ? 0 : col_pos;
        y = row_pos;
        mid_px = line_one_up[x];
        top_px = (y >= 2) ? line_two_up[x] : mid_px;
        // A drain stands for a copy of the middle row below it.
        bot_px = (in_opcode == OP_DRAIN) ? mid_px : in_sample;
        line_two_up[x] = mid_px;
        line_one_up[x] = bot_px;
        if (x == 0) begin
          for (int i = 0; i < 3; i++) begin
            taps[i] = top_px;
            taps[3 + i] = mid_px;
            taps[6 + i] = bot_px;
          end
        end else begin
          shift_column(top_px, mid_px, bot_px);
        end
        py = y - 1'b1;
        n = 0;
        if (y >= 1 && x >= 1) begin
          made[n] = interpolate(x - 1, py, w, h);
          n++;
        end
        // The row's last column also flushes the rightmost pixel, with the
        // right neighbor replicated.
        if (x == w - 1) begin
          if (x >= 1)
            shift_column(taps[2], taps[5], taps[8]);
          if (y >= 1) begin
            made[n] = interpolate(x, py, w, h);
            n++;
          end
        end
        for (int i = 0; i < n; i++) begin
          if (i == n - 1)
            made[i].last = 1'b1;
          expected_pixels.push_back(made[i]);
        end
        if (x >= w - 1) begin
          col_pos = 0;
          row_pos = (in_opcode == OP_DRAIN) ? '0 : y + 1'b1;
        end else begin
          col_pos = x + 1;
        end
      end

      if (out_valid && !out_stall) begin
        got = {out_red, out_green, out_blue, out_row_end, out_frame_end, out_last};
        if (expected_pixels.size() == 0) begin
          flag("pixel with none expected", '0, got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want)
            flag("pixel mismatch", want, got);
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the demosaic testbench: clock, reset, stimulus, flow control and verdict.
module testbench
  import brbd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 4;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          PHASE_ITEMS    = 420;
  localparam int unsigned TIMEOUT_CYCLES = 600_000;

  // Indexes past the two registers; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_opcode;
  logic [PIX_W-1:0]     in_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [PIX_W-1:0]     out_red;
  logic [PIX_W-1:0]     out_green;
  logic [PIX_W-1:0]     out_blue;
  logic                 out_row_end;
  logic                 out_frame_end;
  logic                 out_last;
  int                   mismatches;
  int                   outstanding;

  // Idle rates of the two sides, in percent of cycles.
  int send_idle_pct;
  int recv_idle_pct;

  // Long receiver hold-offs requested by the stimulus and served by the sink.
  int holds_asked = 0;
  int holds_done = 0;

  // Stimulus-side view of where the block stands in its frame. It is only
  // used to keep the stimulus legal: a drain transaction in the first row of
  // a frame copies the stored row entry, so it is only sent for columns that
  // have held a real sample since reset.
  int unsigned stim_w = FRAME_WIDTH_RST;
  int unsigned stim_h = FRAME_HEIGHT_RST;
  int unsigned stim_col = 0;
  int unsigned stim_row = 0;
  bit          line_written [MAX_WIDTH_DEF];
  int          items_sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bayer_rggb_bilinear_demosaic dut (.*);

  demosaic_checker result_checker (.*);

  // Result sink. It stalls at the current random rate, or holds the channel
  // off for a long counted stretch when the stimulus asks for one, so that
  // the output queue fills and the block pushes back on its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_asked > holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offers one transaction and returns at the falling edge after it was
  // taken. Called at a falling edge; valid is only touched once per edge.
  task automatic push(input logic op, input logic [PIX_W-1:0] value);
    logic use_op;
    use_op = op;
    if (use_op == OP_DRAIN && stim_row == 0 && !line_written[stim_col])
      use_op = OP_SAMPLE;
    if (use_op == OP_SAMPLE)
      line_written[stim_col] = 1'b1;
    if (stim_col >= stim_w - 1) begin
      stim_col = 0;
      stim_row = (use_op == OP_DRAIN) ? 0 : stim_row + 1;
    end else begin
      stim_col++;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_opcode <= 1'($urandom_range(0, 1));
      in_sample <= PIX_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= use_op;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Lets every expected pixel come out, then waits out the pipeline so that
  // transactions which make no pixel (the first row) are finished as well.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_FRAME_WIDTH) begin
      stim_w = (value == 0) ? 1 : (value > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : value;
      stim_col = 0;
      stim_row = 0;
    end else if (idx == REG_FRAME_HEIGHT) begin
      stim_h = (value == 0) ? 1 : value;
      stim_col = 0;
      stim_row = 0;
    end
  endtask

  // Sends a frame of the given number of sample rows followed by one drain
  // row. With mix set, drains also land inside the sample rows; a nonzero cut
  // stops the frame after that many transactions; hold asks for a long
  // receiver hold-off as the second row begins.
  task automatic send_frame(input int rows, input bit mix, input int cut, input bit hold);
    int   total;
    logic op;
    total = (rows + 1) * stim_w;
    for (int i = 0; i < total; i++) begin
      if (cut != 0 && i == cut)
        break;
      if (hold && i == stim_w)
        holds_asked++;
      if (i >= rows * stim_w)
        op = OP_DRAIN;
      else if (mix && stim_row != 0 && $urandom_range(0, 3) == 0)
        op = OP_DRAIN;
      else
        op = OP_SAMPLE;
      push(op, ($urandom_range(0, 9) == 0) ? 8'hFF :
               ($urandom_range(0, 9) == 0) ? 8'h00 : PIX_W'($urandom));
    end
  endtask

  // Random frames. Most are well formed with random sizes and content; the
  // rest run past the frame height, mix drains into the sample rows, or are
  // cut short and then restarted by a register write.
  task automatic random_phase(input int target);
    int start;
    int k;
    int rows;
    int cut;
    start = items_sent;
    while (items_sent - start < target) begin
      k = $urandom_range(0, 99);
      if (k < 50 || stim_col != 0 || stim_row != 0) begin
        settle();
        k = $urandom_range(0, 99);
        cfg_write(REG_FRAME_WIDTH, (k < 5) ? CFG_W'(0) :
                                   (k < 15) ? CFG_W'($urandom_range(17, 80)) :
                                   CFG_W'($urandom_range(1, 16)));
        k = $urandom_range(0, 99);
        cfg_write(REG_FRAME_HEIGHT, (k < 4) ? CFG_W'(0) :
                                    (k < 8) ? CFG_W'(MAX_WIDTH_DEF) :
                                    (k < 12) ? {CFG_W{1'b1}} :
                                    CFG_W'($urandom_range(1, 6)));
      end else if (k < 56) begin
        settle();
        cfg_write(($urandom_range(0, 1) == 0) ? UNUSED_IDX_LO : UNUSED_IDX_HI,
                  CFG_W'($urandom));
      end
      rows = (stim_h <= 8) ? stim_h : $urandom_range(1, 6);
      k = $urandom_range(0, 99);
      if (k < 10)
        rows += $urandom_range(1, 2);
      cut = (k >= 25 && k < 35) ? $urandom_range(1, (rows + 1) * stim_w - 1) : 0;
      send_frame(rows, k >= 10 && k < 25, cut, 1'b0);
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = OP_SAMPLE;
    in_sample = '0;
    send_idle_pct = 13;
    recv_idle_pct = 45;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A 4x2 checkerboard of full-scale and zero samples. The first row only
    // fills the line stores; the second row and the drain row bring out
    // both pixel rows, each row end giving two pixels at once.
    cfg_write(REG_FRAME_WIDTH, CFG_W'(4));
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(2));
    for (int i = 0; i < 8; i++)
      push(OP_SAMPLE, ((i + i / 4) % 2 == 0) ? 8'hFF : 8'h00);
    for (int i = 0; i < 4; i++)
      push(OP_DRAIN, 8'hA5);

    // Zero in both registers is used as a one-pixel, one-row frame. The
    // second sample row lies past the frame height.
    settle();
    cfg_write(REG_FRAME_WIDTH, '0);
    cfg_write(REG_FRAME_HEIGHT, '0);
    push(OP_SAMPLE, 8'hFF);
    push(OP_SAMPLE, 8'h00);
    push(OP_DRAIN, 8'h5A);

    // Writes past the register list change nothing, not even the frame
    // position.
    settle();
    cfg_write(UNUSED_IDX_LO, {CFG_W{1'b1}});
    cfg_write(UNUSED_IDX_HI, '0);

    // Three wide with the largest height: a drain in the middle of the
    // second row, then a drain row that ends the frame with no frame end.
    cfg_write(REG_FRAME_WIDTH, CFG_W'(3));
    cfg_write(REG_FRAME_HEIGHT, {CFG_W{1'b1}});
    push(OP_SAMPLE, 8'h00);
    push(OP_SAMPLE, 8'hFF);
    push(OP_SAMPLE, 8'h80);
    push(OP_SAMPLE, 8'h7F);
    push(OP_DRAIN, 8'hFF);
    push(OP_SAMPLE, 8'h01);
    for (int i = 0; i < 3; i++)
      push(OP_DRAIN, 8'h00);

    // Back pressure: the sink holds off while the sender keeps offering.
    settle();
    cfg_write(REG_FRAME_WIDTH, CFG_W'(12));
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(4));
    send_frame(4, 1'b0, 0, 1'b1);
    random_phase(PHASE_ITEMS);

    send_idle_pct = 45;
    recv_idle_pct = 13;
    random_phase(PHASE_ITEMS);

    // Full rate on both sides, with another hold-off and the start of two
    // frames of the largest width (an all-ones width is used as the maximum).
    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle();
    cfg_write(REG_FRAME_WIDTH, CFG_W'(12));
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(4));
    send_frame(4, 1'b0, 0, 1'b1);
    settle();
    cfg_write(REG_FRAME_WIDTH, {CFG_W{1'b1}});
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(1));
    send_frame(1, 1'b0, 100, 1'b0);
    settle();
    cfg_write(REG_FRAME_WIDTH, CFG_W'(MAX_WIDTH_DEF));
    send_frame(1, 1'b0, 100, 1'b0);
    random_phase(PHASE_ITEMS);

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("bayer_rggb_bilinear_demosaic test passed");
    else
      $display("bayer_rggb_bilinear_demosaic test failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("bayer_rggb_bilinear_demosaic test failed");
    $finish;
  end

endmodule
